### design/bpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpm_pkg
// Shared types, register indexes and helper functions for the byte pattern
// matcher.
// ----------------------------------------------------------------------------
package bpm_pkg;

  // Default values for the top-level parameters.
  localparam int PATTERN_MAX_DEFAULT  = 16;
  localparam int OFFSET_WIDTH_DEFAULT = 32;

  // Fixed field widths.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int LEN_W       = 5;
  localparam int RESULT_W    = 32;
  localparam int WINDOW_BYTES = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FOLD_CASE      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INVERT_REPORT  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REPORT_LIMIT   = 3'd5;

  typedef struct packed {
    logic [63:0]          pattern_low;
    logic [63:0]          pattern_high;
    logic [LEN_W-1:0]     pattern_length;
    logic                 fold_case;
    logic                 invert_report;
    logic [RESULT_W-1:0]  report_limit;
  } cfg_t;

  typedef struct packed {
    logic [RESULT_W-1:0] match_offset;
    logic [RESULT_W-1:0] report_number;
  } result_t;

  // Maps A-Z to a-z when folding is enabled; every other byte passes as is.
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = b;
    if (en && (b >= 8'h41) && (b <= 8'h5A)) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  // A length of zero acts as one, and anything beyond the cap is clamped.
  function automatic logic [LEN_W-1:0] effective_length(input logic [LEN_W-1:0] len,
                                                         input int cap);
    logic [LEN_W-1:0] r;
    r = len;
    if (len == '0) begin
      r = LEN_W'(1);
    end else if (len > LEN_W'(cap)) begin
      r = LEN_W'(cap);
    end
    return r;
  endfunction

endpackage

### design/bpm_compare.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpm_compare
// Parallel byte compare of the window against the pattern, with optional
// case folding on both sides.
// ----------------------------------------------------------------------------
module bpm_compare #(
  parameter int PATTERN_MAX = bpm_pkg::PATTERN_MAX_DEFAULT
) (
  input  logic [PATTERN_MAX*8-1:0]   window,
  input  bpm_pkg::cfg_t              cfg,
  input  logic [bpm_pkg::LEN_W-1:0]  length,
  output logic                       match
);
  import bpm_pkg::*;

  localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [WINDOW_BYTES*8-1:0] pattern;

  assign pattern = {cfg.pattern_high, cfg.pattern_low};

  // Pattern byte i lines up with window byte length-1-i, since window byte 0
  // is the newest one.
  always_comb begin
    logic [IDX_W-1:0] idx;
    logic [7:0]       wb;
    logic [7:0]       pb;
    match = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      idx = '0;
      wb  = '0;
      pb  = '0;
      if (LEN_W'(i) < length) begin
        idx = IDX_W'(length - LEN_W'(i) - LEN_W'(1));
        wb  = window[idx*8 +: 8];
        pb  = pattern[i*8 +: 8];
        if (fold_byte(wb, cfg.fold_case) != fold_byte(pb, cfg.fold_case)) begin
          match = 1'b0;
        end
      end
    end
  end

endmodule

### design/bpm_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpm_skid
// Result register with a skid entry, so the input side keeps running while
// a result waits for the consumer.
// ----------------------------------------------------------------------------
module bpm_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bpm_pkg::result_t  load_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bpm_pkg::result_t  out_data,
  output logic              full
);
  import bpm_pkg::*;

  logic    main_valid;
  logic    skid_valid;
  result_t main;
  result_t skid;
  logic    take;
  logic    load_main;
  logic    load_skid;
  logic    move_skid;

  assign take      = main_valid && !out_stall;
  assign move_skid = skid_valid && take;
  assign load_main = load && !skid_valid && (!main_valid || take);
  assign load_skid = load && !skid_valid && main_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (move_skid) begin
        skid_valid <= 1'b0;
      end else if (load_skid) begin
        skid_valid <= 1'b1;
      end
      if (move_skid || load_main) begin
        main_valid <= 1'b1;
      end else if (take) begin
        main_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move_skid) begin
      main <= skid;
    end else if (load_main) begin
      main <= load_data;
    end
    if (load_skid) begin
      skid <= load_data;
    end
  end

  assign out_valid = main_valid;
  assign out_data  = main;
  assign full      = skid_valid;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry holds data while the result register is empty");

  a_park_on_stall: assert property (@(posedge clk) disable iff (rst)
    load && main_valid && out_stall |=> skid_valid)
    else $error("result arriving behind a stalled one was not parked");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !out_stall |=> main_valid && !skid_valid)
    else $error("skid entry did not move into the result register");

endmodule

### design/byte_pattern_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_pattern_matcher
// Brute-force substring search over a byte stream: a sliding window of the
// most recent bytes is compared against a programmable pattern of up to
// sixteen bytes, and matching (or, in invert mode, non-matching) starting
// offsets are reported with a running report count.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ---------------------------
//  data     in         data_valid / data_stall    data_byte, start_of_data
//  report   out        report_valid / report_stall match_offset, report_number
//  cfg      in         cfg_write_enable           cfg_index, cfg_data
//
// Each byte is processed as it is accepted, and a new byte can be accepted on every
// clock while data_stall is low. The path that sets the cycle time is the window
// shift followed by the folded sixteen-byte compare and the report limit
// check, all feeding the result register.
// A result is loaded into the result register, or into the skid entry if that one still holds a stalled result.
// The report channel has a result register plus one skid entry; data_stall
// rises only when both hold a result, i.e. while the consumer has stalled.
// Reset (rst, synchronous) returns the registers to their defaults and clears
// the window, counters and the limit flag; there is no clearing pass.
// ----------------------------------------------------------------------------
module byte_pattern_matcher #(
  parameter int PATTERN_MAX  = bpm_pkg::PATTERN_MAX_DEFAULT,
  parameter int OFFSET_WIDTH = bpm_pkg::OFFSET_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_enable,
  input  logic [bpm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bpm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             data_valid,
  output logic                             data_stall,
  input  logic [7:0]                       data_byte,
  input  logic                             start_of_data,
  output logic                             report_valid,
  input  logic                             report_stall,
  output logic [bpm_pkg::RESULT_W-1:0]     match_offset,
  output logic [bpm_pkg::RESULT_W-1:0]     report_number
);
  import bpm_pkg::*;

  // Offsets are worked out at the full counter width and then cut or
  // extended to the result width.
  localparam int EXT_W = (OFFSET_WIDTH > RESULT_W) ? OFFSET_WIDTH : RESULT_W;

  // Configuration registers.
  cfg_t cfg;

  // Stream state.
  logic [PATTERN_MAX*8-1:0] window;
  logic [OFFSET_WIDTH-1:0]  bytes_seen;
  logic [RESULT_W-1:0]      reports_made;
  logic                     limit_reached;

  logic [PATTERN_MAX*8-1:0] window_next;
  logic [OFFSET_WIDTH-1:0]  bytes_seen_next;
  logic [RESULT_W-1:0]      reports_made_next;
  logic                     limit_reached_next;

  logic                     accept;
  logic [PATTERN_MAX*8-1:0] base_window;
  logic [OFFSET_WIDTH-1:0]  base_seen;
  logic [RESULT_W-1:0]      base_reports;
  logic                     base_limit;
  logic [LEN_W-1:0]         length;
  logic                     window_full;
  logic                     match;
  logic                     report_due;
  logic                     emit;
  logic [OFFSET_WIDTH-1:0]  offset_diff;
  logic [EXT_W-1:0]         offset_ext;
  result_t                  result;
  result_t                  out_data;
  logic                     skid_full;

  assign accept     = data_valid && !data_stall;
  assign data_stall = skid_full;

  // Register writes. Indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_low    <= '0;
      cfg.pattern_high   <= '0;
      cfg.pattern_length <= LEN_W'(1);
      cfg.fold_case      <= 1'b0;
      cfg.invert_report  <= 1'b0;
      cfg.report_limit   <= '0;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    cfg.pattern_low    <= cfg_data;
        REG_PATTERN_HIGH:   cfg.pattern_high   <= cfg_data;
        REG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[LEN_W-1:0];
        REG_FOLD_CASE:      cfg.fold_case      <= cfg_data[0];
        REG_INVERT_REPORT:  cfg.invert_report  <= cfg_data[0];
        REG_REPORT_LIMIT:   cfg.report_limit   <= cfg_data[RESULT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A start flag wipes the window and counters before its own byte goes in.
  assign base_window  = start_of_data ? '0 : window;
  assign base_seen    = start_of_data ? '0 : bytes_seen;
  assign base_reports = start_of_data ? '0 : reports_made;
  assign base_limit   = start_of_data ? 1'b0 : limit_reached;

  // Newest byte enters at the bottom of the window.
  generate
    if (PATTERN_MAX > 1) begin : g_shift
      assign window_next = {base_window[PATTERN_MAX*8-9:0], data_byte};
    end else begin : g_single
      assign window_next = data_byte;
    end
  endgenerate

  // The byte counter sticks at all ones rather than wrapping.
  assign bytes_seen_next = (base_seen == '1) ? base_seen
                                             : base_seen + OFFSET_WIDTH'(1);

  assign length      = effective_length(cfg.pattern_length, PATTERN_MAX);
  assign window_full = bytes_seen_next >= OFFSET_WIDTH'(length);

  bpm_compare #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_compare (
    .window(window_next),
    .cfg   (cfg),
    .length(length),
    .match (match)
  );

  assign report_due  = window_full && !base_limit && (match != cfg.invert_report);
  assign offset_diff = bytes_seen_next - OFFSET_WIDTH'(length);
  assign offset_ext  = EXT_W'(offset_diff);

  // Once a due report finds the count at the limit, reporting stops until
  // the next start flag or reset. The report count sticks at all ones.
  always_comb begin
    reports_made_next  = base_reports;
    limit_reached_next = base_limit;
    emit               = 1'b0;
    if (report_due) begin
      if ((cfg.report_limit != '0) && (base_reports >= cfg.report_limit)) begin
        limit_reached_next = 1'b1;
      end else begin
        emit = 1'b1;
        if (base_reports != '1) begin
          reports_made_next = base_reports + RESULT_W'(1);
        end
      end
    end
    result.match_offset  = offset_ext[RESULT_W-1:0];
    result.report_number = reports_made_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      bytes_seen    <= '0;
      reports_made  <= '0;
      limit_reached <= 1'b0;
    end else if (accept) begin
      window        <= window_next;
      bytes_seen    <= bytes_seen_next;
      reports_made  <= reports_made_next;
      limit_reached <= limit_reached_next;
    end
  end

  bpm_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && emit),
    .load_data(result),
    .out_valid(report_valid),
    .out_stall(report_stall),
    .out_data (out_data),
    .full     (skid_full)
  );

  assign match_offset  = out_data.match_offset;
  assign report_number = out_data.report_number;

  a_stall_means_pending: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> report_valid)
    else $error("input stalled with no result pending on the report channel");

  a_limit_sticks: assert property (@(posedge clk) disable iff (rst)
    limit_reached && !(accept && start_of_data) |=> limit_reached)
    else $error("report limit flag cleared without a start flag");

  a_report_number_nonzero: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> report_number != '0)
    else $error("report delivered with a zero report count");

endmodule
